// ===== rtl/wsdefr_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by websocket_frame_deframer_core.
package wsdefr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned OpcodeW = 7;
  localparam int unsigned LenW    = 16;
  localparam int unsigned KeyN    = 4;
  localparam int unsigned KeyIdxW = $clog2(KeyN);
  localparam int unsigned KindW   = 2;
  localparam int unsigned OutDataW = 16;

  localparam logic [6:0] Len7Ext16 = 7'd126;
  localparam logic [6:0] Len7Ext64 = 7'd127;

  typedef enum logic [KindW-1:0] {
    KIND_DATA   = 2'd0,
    KIND_EMPTY  = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_ABORT  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [ByteW-1:0]    data_byte;
    logic [OpcodeW-1:0]  opcode;
    logic                last;
  } result_t;

endpackage

// ===== rtl/websocket_frame_deframer_core.sv =====
// WebSocket frame deframer: parses received bytes into payload and status words.
// Depends on wsdefr_pkg for widths, result kinds and the result struct.
//
//  channel | dir | tdata                              | tuser          | tlast
//  in_     | in  | [7:0] rx_byte                      | [0] link_abort | -
//  out_    | out | [7:0] data_byte, [14:8] opcode,    | [1:0] kind     | last
//          |     | [15] zero                          |                |
//
// One word is accepted per cycle; the accepting edge updates the parser state and
// loads any result into the output register, which offers it in the next cycle.
// The input is ready whenever the output register is empty or is being drained,
// so a stall on the output holds back the input only while a result is waiting.
// Reset (rst_n low, synchronous) returns the parser to the first header byte.
module websocket_frame_deframer_core
  import wsdefr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [ByteW-1:0]    in_tdata,   // [7:0] rx_byte
  input  logic                in_tuser,   // [0] link_abort
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // [7:0] data_byte, [14:8] opcode, [15] zero
  output logic [KindW-1:0]    out_tuser,  // [1:0] kind
  output logic                out_tlast   // last
);

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_LENHI = 3'd2,
    PH_LENLO = 3'd3,
    PH_KEY   = 3'd4,
    PH_DATA  = 3'd5
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [OpcodeW-1:0]   opcode_r, opcode_nxt;
  logic                 masked_r, masked_nxt;
  logic [LenW-1:0]      len_r, len_nxt;
  logic [LenW-1:0]      cnt_r, cnt_nxt;
  logic [ByteW-1:0]     key_r [KeyN];
  logic [KeyIdxW-1:0]   kidx_r, kidx_nxt;
  logic                 key_we;

  logic                 out_valid_r;
  result_t              res_r, res_nxt;
  logic                 emit;
  logic                 accept;

  logic [6:0]           len7;
  logic [LenW-1:0]      len_after;
  logic                 len_known;
  logic [LenW-1:0]      cnt_inc;
  logic [ByteW-1:0]     key_sel;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign len7    = in_tdata[6:0];
  assign cnt_inc = cnt_r + LenW'(1);
  assign key_sel = masked_r ? key_r[cnt_r[KeyIdxW-1:0]] : '0;

  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    masked_nxt = masked_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    kidx_nxt   = kidx_r;
    key_we     = 1'b0;
    emit       = 1'b0;
    len_known  = 1'b0;
    len_after  = len_r;
    res_nxt.kind      = KIND_DATA;
    res_nxt.data_byte = '0;
    res_nxt.opcode    = opcode_r;
    res_nxt.last      = 1'b0;

    if (in_tuser) begin
      if (phase_r != PH_HDR0) begin
        phase_nxt    = PH_HDR0;
        cnt_nxt      = '0;
        kidx_nxt     = '0;
        emit         = 1'b1;
        res_nxt.kind = KIND_ABORT;
      end
    end else begin
      unique case (phase_r)
        PH_HDR0: begin
          opcode_nxt = in_tdata[OpcodeW-1:0];
          phase_nxt  = PH_HDR1;
        end
        PH_HDR1: begin
          masked_nxt = in_tdata[ByteW-1];
          if (len7 == Len7Ext64) begin
            phase_nxt    = PH_HDR0;
            emit         = 1'b1;
            res_nxt.kind = KIND_REJECT;
          end else if (len7 == Len7Ext16) begin
            phase_nxt = PH_LENHI;
          end else begin
            len_after = LenW'(len7);
            len_known = 1'b1;
          end
        end
        PH_LENHI: begin
          len_nxt   = {in_tdata, {(LenW-ByteW){1'b0}}};
          phase_nxt = PH_LENLO;
        end
        PH_LENLO: begin
          len_after = len_r | LenW'(in_tdata);
          len_known = 1'b1;
        end
        PH_KEY: begin
          key_we = 1'b1;
          if (kidx_r == KeyIdxW'(KeyN - 1)) begin
            kidx_nxt = '0;
            cnt_nxt  = '0;
            if (len_r == '0) begin
              phase_nxt    = PH_HDR0;
              emit         = 1'b1;
              res_nxt.kind = KIND_EMPTY;
              res_nxt.last = 1'b1;
            end else begin
              phase_nxt = PH_DATA;
            end
          end else begin
            kidx_nxt = kidx_r + KeyIdxW'(1);
          end
        end
        PH_DATA: begin
          emit              = 1'b1;
          res_nxt.data_byte = in_tdata ^ key_sel;
          if (cnt_inc == len_r) begin
            res_nxt.last = 1'b1;
            phase_nxt    = PH_HDR0;
            cnt_nxt      = '0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        default: begin
          phase_nxt = PH_HDR0;
        end
      endcase

      // Length settled: start key collection, start payload, or report an empty frame.
      if (len_known) begin
        len_nxt = len_after;
        if (masked_nxt) begin
          kidx_nxt  = '0;
          phase_nxt = PH_KEY;
        end else begin
          cnt_nxt = '0;
          if (len_after == '0) begin
            phase_nxt    = PH_HDR0;
            emit         = 1'b1;
            res_nxt.kind = KIND_EMPTY;
            res_nxt.last = 1'b1;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR0;
      opcode_r    <= '0;
      masked_r    <= 1'b0;
      len_r       <= '0;
      cnt_r       <= '0;
      kidx_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < KeyN; i++) begin
        key_r[i] <= '0;
      end
    end else begin
      if (accept) begin
        phase_r  <= phase_nxt;
        opcode_r <= opcode_nxt;
        masked_r <= masked_nxt;
        len_r    <= len_nxt;
        cnt_r    <= cnt_nxt;
        kidx_r   <= kidx_nxt;
        if (key_we) begin
          key_r[kidx_r] <= in_tdata;
        end
        out_valid_r <= emit;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r.opcode, res_r.data_byte};
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.last;

endmodule

// ===== sim/websocket_frame_deframer_core_tb.sv =====
// Self-checking testbench for websocket_frame_deframer_core: random WebSocket frames,
// aborts and noise in, each result word checked against a frame parser kept in the bench.
// Depends on wsdefr_pkg and the websocket_frame_deframer_core RTL.
`timescale 1ns / 100ps

module websocket_frame_deframer_core_tb;
  import wsdefr_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_LENHI = 3'd2,
    PH_LENLO = 3'd3,
    PH_KEY   = 3'd4,
    PH_DATA  = 3'd5
  } parse_phase_t;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic             link_abort;
  } rx_word_t;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [ByteW-1:0]    in_tdata   = '0;
  logic                in_tuser   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic [KindW-1:0]    out_tuser;
  logic                out_tlast;

  rx_word_t tx_words[$];
  result_t  pending_results[$];

  // Shadow of the parser state.
  parse_phase_t      ph   = PH_HDR0;
  logic [OpcodeW-1:0] op  = '0;
  logic               msk = 1'b0;
  logic [LenW-1:0]    plen = '0;
  logic [LenW-1:0]    cnt  = '0;
  logic [ByteW-1:0]   key[KeyN] = '{default: '0};
  logic [KeyIdxW-1:0] kidx = '0;

  int gap_left     = 0;
  int stall_left   = 0;
  int tx_calm      = 0;
  int rx_calm      = 0;
  int hold_left    = 0;
  int hold_runs    = 0;
  int words_sent   = 0;
  int frames_built = 0;
  int mismatches   = 0;
  int kinds_seen[4] = '{default: 0};

  websocket_frame_deframer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 4) begin
      calm_left = $urandom_range(60, 20);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic bit header_empty();
    cnt = '0;
    if (plen == '0) begin
      ph = PH_HDR0;
      return 1'b1;
    end
    ph = PH_DATA;
    return 1'b0;
  endfunction

  function automatic bit length_known_empty();
    if (msk) begin
      kidx = '0;
      ph = PH_KEY;
      return 1'b0;
    end
    return header_empty();
  endfunction

  function automatic bit deframe_byte(input logic [ByteW-1:0] b, input logic abort_in,
                                      output result_t res);
    bit               hit;
    bit               empty;
    logic [6:0]       len7;
    logic [ByteW-1:0] k;
    hit = 1'b0;
    empty = 1'b0;
    res = '0;
    if (abort_in) begin
      if (ph != PH_HDR0) begin
        ph = PH_HDR0;
        cnt = '0;
        kidx = '0;
        res.kind = KIND_ABORT;
        hit = 1'b1;
      end
    end else begin
      case (ph)
        PH_HDR0: begin
          op = b[6:0];
          ph = PH_HDR1;
        end
        PH_HDR1: begin
          len7 = b[6:0];
          msk = b[7];
          if (len7 == Len7Ext64) begin
            ph = PH_HDR0;
            res.kind = KIND_REJECT;
            hit = 1'b1;
          end else if (len7 == Len7Ext16) begin
            ph = PH_LENHI;
          end else begin
            plen = LenW'(len7);
            empty = length_known_empty();
          end
        end
        PH_LENHI: begin
          plen = {b, 8'h00};
          ph = PH_LENLO;
        end
        PH_LENLO: begin
          plen = plen | LenW'(b);
          empty = length_known_empty();
        end
        PH_KEY: begin
          key[kidx] = b;
          if (kidx == KeyIdxW'(KeyN - 1)) begin
            kidx = '0;
            empty = header_empty();
          end else begin
            kidx = kidx + 1'b1;
          end
        end
        PH_DATA: begin
          k = msk ? key[cnt[KeyIdxW-1:0]] : '0;
          cnt = cnt + 1'b1;
          res.kind = KIND_DATA;
          res.data_byte = b ^ k;
          res.last = (cnt == plen);
          if (res.last) begin
            ph = PH_HDR0;
            cnt = '0;
          end
          hit = 1'b1;
        end
        default: ph = PH_HDR0;
      endcase
    end
    if (empty) begin
      res.kind = KIND_EMPTY;
      res.last = 1'b1;
      hit = 1'b1;
    end
    res.opcode = op;
    return hit;
  endfunction

  task automatic push_word(input logic [ByteW-1:0] b, input logic ab);
    tx_words.push_back('{rx_byte: b, link_abort: ab});
  endtask

  // A frame header, optional mask key and random payload; a cut position below the
  // frame size truncates it there and follows with an abort.
  task automatic add_frame(input logic [ByteW-1:0] hdr0, input bit masked, input int len,
                           input bit wide, input int cut);
    logic [ByteW-1:0] bytes[$];
    bytes.push_back(hdr0);
    if (wide) begin
      bytes.push_back({masked, Len7Ext16});
      bytes.push_back(len[15:8]);
      bytes.push_back(len[7:0]);
    end else begin
      bytes.push_back({masked, len[6:0]});
    end
    if (masked) repeat (KeyN) bytes.push_back(ByteW'($urandom));
    repeat (len) bytes.push_back(ByteW'($urandom));
    if (cut >= 0 && cut < bytes.size()) bytes = bytes[0:cut-1];
    foreach (bytes[i]) push_word(bytes[i], 1'b0);
    if (cut >= 0 && cut < bytes.size() + 1 && cut == bytes.size())
      push_word(ByteW'($urandom), 1'b1);
    frames_built++;
  endtask

  // Driver: offers queued words, predicting the results of each accepted one.
  always @(posedge clk) begin
    result_t res;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (deframe_byte(in_tdata, in_tuser, res)) pending_results.push_back(res);
        words_sent++;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (tx_words.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= tx_words[0].rx_byte;
          in_tuser  <= tx_words[0].link_abort;
          void'(tx_words.pop_front());
          gap_left = (hold_left != 0) ? 0 : pick_gap(tx_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-offs so that a waiting result backs up the input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((hold_runs == 0 && words_sent >= 150) ||
                 (hold_runs == 1 && words_sent >= 350)) begin
      hold_left <= 90;
      hold_runs <= hold_runs + 1;
    end
  end

  task automatic note_mismatch(input string what, input result_t want);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t: %s: expected kind %0d data %02h opcode %02h last %0b, ",
                "got kind %0d data %02h opcode %02h last %0b pad %0b"},
               $realtime, what, want.kind, want.data_byte, want.opcode, want.last,
               out_tuser, out_tdata[7:0], out_tdata[14:8], out_tlast, out_tdata[15]);
  endtask

  // Monitor: checks each accepted result word against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        kinds_seen[out_tuser]++;
        if (pending_results.size() == 0) begin
          note_mismatch("unexpected result", '0);
        end else begin
          want = pending_results.pop_front();
          if (out_tuser !== want.kind || out_tlast !== want.last ||
              out_tdata !== {1'b0, want.opcode, want.data_byte})
            note_mismatch("result mismatch", want);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (hold_left != 0) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        stall_left = pick_gap(rx_calm);
      end
    end
  end

  initial begin
    int target;
    int r;
    bit big_done;
    big_done = 1'b0;

    push_word(8'hFF, 1'b1);
    add_frame(8'hFF, 1'b0, 0, 1'b1, -1);
    push_word(8'h00, 1'b0);
    push_word(8'hFF, 1'b0);
    add_frame(8'h8A, 1'b1, 0, 1'b0, -1);
    add_frame(8'h81, 1'b1, 5, 1'b1, -1);
    add_frame(8'h02, 1'b0, 3, 1'b0, 3);

    target = 450;
    while (tx_words.size() < target) begin
      r = $urandom_range(99);
      if (!big_done && tx_words.size() > 200) begin
        add_frame(ByteW'($urandom), 1'($urandom), 256 + $urandom_range(20), 1'b1, -1);
        big_done = 1'b1;
      end else if (r < 72) begin
        add_frame(ByteW'($urandom), 1'($urandom),
                  ($urandom_range(9) == 0) ? 0 : $urandom_range(20, 1),
                  $urandom_range(3) == 0,
                  ($urandom_range(11) == 0) ? $urandom_range(20, 1) : -1);
      end else if (r < 82) begin
        push_word(ByteW'($urandom), 1'b0);
        push_word({1'($urandom), Len7Ext64}, 1'b0);
      end else begin
        repeat ($urandom_range(6, 1)) push_word(ByteW'($urandom), $urandom_range(3) == 0);
        push_word(ByteW'($urandom), 1'b1);
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (tx_words.size() != 0 || in_tvalid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d words in %0d frames plus noise and aborts, with long output stalls.",
             words_sent, frames_built);
    $display("Checked results: %0d data, %0d empty, %0d rejected, %0d aborted.",
             kinds_seen[KIND_DATA], kinds_seen[KIND_EMPTY], kinds_seen[KIND_REJECT],
             kinds_seen[KIND_ABORT]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** websocket_frame_deframer_core: PASSED **");
    end else begin
      $display("** websocket_frame_deframer_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #4800000;
    $display("Timed out with %0d words queued and %0d results outstanding.",
             tx_words.size(), pending_results.size());
    $display("** websocket_frame_deframer_core: FAILED **");
    $finish;
  end

endmodule
